FILE: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator: request and
// response structs, status codes, configuration register indexes and widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

	// pool geometry
	localparam int MAX_BLOCKS = 64;
	localparam int ADDR_W     = 32;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int SIZE_W     = 17;
	localparam int STEP_W     = $clog2(ADDR_W);
	localparam int UNIT_W     = ADDR_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd2;

	// reset values of the configuration registers
	localparam logic [ADDR_W-1:0] BASE_RESET  = '0;
	localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(16);
	localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(MAX_BLOCKS);

	// request kinds
	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	// response status codes
	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NO_BLOCK     = 3'd1,
		ST_RANGE        = 3'd2,
		ST_MISALIGNED   = 3'd3,
		ST_ALREADY_FREE = 3'd4
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  block_address;
		status_t            status;
	} rsp_t;

endpackage

`default_nettype wire

FILE: src/bitmap_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// Fixed-size block allocator over a 64-bit free bitmap. A sequencer drives one
// shared 33-bit add/subtract unit: it steps the block address during the
// allocate scan, forms the free offset and runs a radix-2 restoring divide.
//
//   channel   signals                          direction  transfer when
//   request   start, busy, req                 in         start && !busy
//   response  done, rsp                        out        done (one cycle)
//   config    cfg_valid, cfg_ready,            in         cfg_valid && cfg_ready
//             cfg_index, cfg_data
//
// allocate: the scan visits one block per cycle and answers with the lowest
//   free block, or with no block when the pool is full.
// free: one subtract for the offset, 32 divide steps, then one check.
// busy drops in the cycle that carries done, so a new request can be taken
//   there. The response cannot be held off by the receiver.
// arst_n clears the bitmap to all free and the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_unit
	import bba_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request
	input  wire logic                  start,
	output logic                       busy,
	input  wire req_t                  req,
	// response
	output logic                       done,
	output rsp_t                       rsp,
	// configuration
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_OFFS = 5'b00100,
		S_DIV  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t                state_q;
	logic [ADDR_W-1:0]     base_q;
	logic [SIZE_W-1:0]     size_q;
	logic [CNT_W-1:0]      count_q;
	logic [MAX_BLOCKS-1:0] free_map_q;
	logic [ADDR_W-1:0]     acc_q;
	logic [SIZE_W-1:0]     rem_q;
	logic [CNT_W-1:0]      idx_q;
	logic [STEP_W-1:0]     step_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	logic [SIZE_W-1:0]     size_eff;
	logic [CNT_W-1:0]      count_eff;
	logic [UNIT_W-1:0]     op_a;
	logic [UNIT_W-1:0]     op_b;
	logic                  op_sub;
	logic [UNIT_W:0]       unit_sum;
	logic                  no_borrow;
	logic [SIZE_W:0]       div_part;
	logic                  start_xfer;
	logic                  quot_over;
	logic [IDX_W-1:0]      quot_idx;

	// effective configuration
	assign size_eff  = (size_q == '0) ? SIZE_W'(1) : size_q;
	assign count_eff = (count_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_q;

	assign busy       = (state_q != S_IDLE);
	assign cfg_ready  = ~busy;
	assign start_xfer = start && !busy;
	assign done       = done_q;
	assign rsp        = rsp_q;

	// partial remainder with the next dividend bit shifted in
	assign div_part = {rem_q, acc_q[ADDR_W-1]};

	// shared add/subtract unit operand select
	always_comb begin
		op_a   = {1'b0, acc_q};
		op_b   = UNIT_W'(size_eff);
		op_sub = 1'b0;
		case (state_q)
			S_SCAN: begin
				op_a   = {1'b0, acc_q};
				op_b   = UNIT_W'(size_eff);
				op_sub = 1'b0;
			end
			S_OFFS: begin
				op_a   = {1'b0, acc_q};
				op_b   = {1'b0, base_q};
				op_sub = 1'b1;
			end
			S_DIV: begin
				op_a   = UNIT_W'(div_part);
				op_b   = UNIT_W'(size_eff);
				op_sub = 1'b1;
			end
			default: begin
				op_a   = {1'b0, acc_q};
				op_b   = UNIT_W'(size_eff);
				op_sub = 1'b0;
			end
		endcase
	end

	assign unit_sum  = {1'b0, op_a} + {1'b0, op_b ^ {UNIT_W{op_sub}}} + (UNIT_W + 1)'(op_sub);
	assign no_borrow = unit_sum[UNIT_W];

	// quotient checks after the divide
	assign quot_over = (acc_q >= ADDR_W'(count_eff));
	assign quot_idx  = acc_q[IDX_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RESET;
			size_q  <= SIZE_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_ADDRESS: base_q  <= cfg_data[ADDR_W-1:0];
				REG_BLOCK_SIZE:   size_q  <= cfg_data[SIZE_W-1:0];
				REG_BLOCK_COUNT:  count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, bitmap and response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			free_map_q <= '1;
			done_q     <= 1'b0;
			idx_q      <= '0;
			step_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start_xfer) begin
						idx_q  <= '0;
						step_q <= '0;
						if (req.kind == KIND_ALLOC) begin
							acc_q   <= base_q;
							state_q <= S_SCAN;
						end else begin
							acc_q   <= req.address;
							state_q <= S_OFFS;
						end
					end
				end
				// one block per cycle, address follows in acc_q
				S_SCAN: begin
					if (idx_q >= count_eff) begin
						rsp_q.block_address <= '0;
						rsp_q.status        <= ST_NO_BLOCK;
						done_q              <= 1'b1;
						state_q             <= S_IDLE;
					end else if (free_map_q[idx_q[IDX_W-1:0]]) begin
						free_map_q[idx_q[IDX_W-1:0]] <= 1'b0;
						rsp_q.block_address <= acc_q;
						rsp_q.status        <= ST_OK;
						done_q              <= 1'b1;
						state_q             <= S_IDLE;
					end else begin
						acc_q <= unit_sum[ADDR_W-1:0];
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				// offset from the pool base, wraps below the base
				S_OFFS: begin
					acc_q   <= unit_sum[ADDR_W-1:0];
					rem_q   <= '0;
					state_q <= S_DIV;
				end
				// restoring divide, quotient shifts into acc_q
				S_DIV: begin
					acc_q <= {acc_q[ADDR_W-2:0], no_borrow};
					rem_q <= no_borrow ? unit_sum[SIZE_W-1:0] : div_part[SIZE_W-1:0];
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(ADDR_W - 1)) begin
						state_q <= S_FIN;
					end
				end
				// range, alignment, then bitmap check
				S_FIN: begin
					rsp_q.block_address <= '0;
					if (quot_over) begin
						rsp_q.status <= ST_RANGE;
					end else if (rem_q != '0) begin
						rsp_q.status <= ST_MISALIGNED;
					end else if (free_map_q[quot_idx]) begin
						rsp_q.status <= ST_ALREADY_FREE;
					end else begin
						free_map_q[quot_idx] <= 1'b1;
						rsp_q.status         <= ST_OK;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start_xfer |=> busy)
		else $error("request transfer did not make the unit busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response strobe while sequencer still busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("response strobe without a request in progress");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.block_address == '0))
		else $error("failed request carries a nonzero block address");

	a_map_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(free_map_q) |-> done)
		else $error("bitmap changed without a response");

endmodule

`default_nettype wire
